@@ sv/yck_pkg.sv @@
// shared types and constants for the yuyv color keyed converter
package yck_pkg;

  // fixed-point chroma coefficients, scaled by 256
  localparam int unsigned CoefBlueU  = 454;
  localparam int unsigned CoefRedV   = 359;
  localparam int unsigned CoefGreenU = 88;
  localparam int unsigned CoefGreenV = 183;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 8;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_OUTPUT_MODE   = 3'd0,
    REG_FILTER_ENABLE = 3'd1,
    REG_LUMA_MIN      = 3'd2,
    REG_LUMA_MAX      = 3'd3,
    REG_BLUE_DIFF_MIN = 3'd4,
    REG_BLUE_DIFF_MAX = 3'd5,
    REG_RED_DIFF_MIN  = 3'd6,
    REG_RED_DIFF_MAX  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       output_mode;
    logic       filter_enable;
    logic [7:0] luma_min;
    logic [7:0] luma_max;
    logic [7:0] blue_diff_min;
    logic [7:0] blue_diff_max;
    logic [7:0] red_diff_min;
    logic [7:0] red_diff_max;
  } cfg_t;

  // floored chroma offsets shared by both pixels
  typedef struct packed {
    logic signed [9:0] cb;
    logic signed [9:0] cg;
    logic signed [9:0] cr;
  } chroma_t;

  typedef struct packed {
    logic       write;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] gray;
  } pix_t;

endpackage

@@ sv/yck_chroma.sv @@
// chroma offset terms from the shared u and v bytes
module yck_chroma (
  input  logic [7:0]        chroma_u,
  input  logic [7:0]        chroma_v,
  output yck_pkg::chroma_t  chroma
);
  import yck_pkg::*;

  logic signed [7:0]  du;
  logic signed [7:0]  dv;
  logic signed [17:0] prod_b;
  logic signed [17:0] prod_r;
  logic signed [17:0] prod_g;

  // subtracting 128 from a byte is flipping its top bit
  assign du = {~chroma_u[7], chroma_u[6:0]};
  assign dv = {~chroma_v[7], chroma_v[6:0]};

  assign prod_b = 18'(du) * 18'sd454;
  assign prod_r = 18'(dv) * 18'sd359;
  assign prod_g = 18'(du) * 18'sd88 + 18'(dv) * 18'sd183;

  // dropping the low byte is a floor divide by 256
  assign chroma.cb = prod_b[17:8];
  assign chroma.cr = prod_r[17:8];
  assign chroma.cg = prod_g[17:8];

endmodule

@@ sv/yck_pixel.sv @@
// one output pixel: luma window, clamp and mode select
module yck_pixel (
  input  logic [7:0]        luma,
  input  logic              chroma_ok,
  input  yck_pkg::chroma_t  chroma,
  input  yck_pkg::cfg_t     cfg,
  output yck_pkg::pix_t     pix
);
  import yck_pkg::*;

  logic signed [10:0] ys;
  logic signed [10:0] sum_b;
  logic signed [10:0] sum_g;
  logic signed [10:0] sum_r;
  logic               keep;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    if (v[10]) begin
      return 8'd0;
    end else if (v[9:8] != 2'b00) begin
      return 8'hff;
    end else begin
      return v[7:0];
    end
  endfunction

  assign ys    = {3'b000, luma};
  assign sum_b = ys + 11'(chroma.cb);
  assign sum_g = ys - 11'(chroma.cg);
  assign sum_r = ys + 11'(chroma.cr);

  assign keep = !cfg.filter_enable ||
                (chroma_ok && luma >= cfg.luma_min && luma <= cfg.luma_max);

  always_comb begin
    pix = '0;
    pix.write = keep;
    if (keep) begin
      if (cfg.output_mode) begin
        pix.blue  = clamp_byte(sum_b);
        pix.green = clamp_byte(sum_g);
        pix.red   = clamp_byte(sum_r);
      end else begin
        pix.gray = luma;
      end
    end
  end

endmodule

@@ sv/yuyv_color_keyed_converter.sv @@
// yuyv macropixel to two bgr or gray pixels with color key filter
//
//  channel | handshake          | payload
//  s_      | s_tvalid/s_tready  | tdata y0,u,y1,v; tlast frame end
//  m_      | m_tvalid/m_tready  | tdata two pixels; tuser write flags; tlast frame end
//  cfg_    | cfg_we             | cfg_index, cfg_data
//
// one item per cycle unless m_ stalls; an item goes from input register to result register
// rst clears the valid flags and loads the register defaults
// a stall on m_ holds the result; s_ still takes an item while the input register is empty
module yuyv_color_keyed_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // luma_first, chroma_u, luma_second, chroma_v
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [63:0]                         m_tdata,   // first b,g,r,gray; second b,g,r,gray
  output logic [1:0]                          m_tuser,   // first_write, second_write
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [yck_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [yck_pkg::CfgDataWidth-1:0]    cfg_data
);
  import yck_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [31:0] in_data;
  logic       in_last;
  logic       in_advance;
  logic       out_free;
  logic       chroma_ok;
  chroma_t    chroma;
  pix_t       pix_first;
  pix_t       pix_second;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode   <= 1'b1;
      cfg.filter_enable <= 1'b0;
      cfg.luma_min      <= 8'd0;
      cfg.luma_max      <= 8'hff;
      cfg.blue_diff_min <= 8'd0;
      cfg.blue_diff_max <= 8'hff;
      cfg.red_diff_min  <= 8'd0;
      cfg.red_diff_max  <= 8'hff;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUTPUT_MODE:   cfg.output_mode   <= cfg_data[0];
        REG_FILTER_ENABLE: cfg.filter_enable <= cfg_data[0];
        REG_LUMA_MIN:      cfg.luma_min      <= cfg_data;
        REG_LUMA_MAX:      cfg.luma_max      <= cfg_data;
        REG_BLUE_DIFF_MIN: cfg.blue_diff_min <= cfg_data;
        REG_BLUE_DIFF_MAX: cfg.blue_diff_max <= cfg_data;
        REG_RED_DIFF_MIN:  cfg.red_diff_min  <= cfg_data;
        REG_RED_DIFF_MAX:  cfg.red_diff_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free   = !m_tvalid || m_tready;
  assign in_advance = in_valid && out_free;
  assign s_tready   = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  yck_chroma u_chroma (
    .chroma_u (in_data[15:8]),
    .chroma_v (in_data[31:24]),
    .chroma   (chroma)
  );

  assign chroma_ok = in_data[15:8]  >= cfg.blue_diff_min && in_data[15:8]  <= cfg.blue_diff_max &&
                     in_data[31:24] >= cfg.red_diff_min  && in_data[31:24] <= cfg.red_diff_max;

  yck_pixel u_pixel_first (
    .luma      (in_data[7:0]),
    .chroma_ok (chroma_ok),
    .chroma    (chroma),
    .cfg       (cfg),
    .pix       (pix_first)
  );

  yck_pixel u_pixel_second (
    .luma      (in_data[23:16]),
    .chroma_ok (chroma_ok),
    .chroma    (chroma),
    .cfg       (cfg),
    .pix       (pix_second)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
    if (in_advance) begin
      m_tdata <= {pix_second.gray, pix_second.red, pix_second.green, pix_second.blue,
                  pix_first.gray,  pix_first.red,  pix_first.green,  pix_first.blue};
      m_tuser <= {pix_second.write, pix_first.write};
      m_tlast <= in_last;
    end
  end

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && !m_tvalid |=> m_tvalid)
    else $error("item in input register did not reach result register");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
    else $error("dropped first pixel carries data");

  a_color_no_gray: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cfg.output_mode |-> m_tdata[31:24] == 8'd0 && m_tdata[63:56] == 8'd0)
    else $error("gray field set in color mode");

  a_gray_no_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !cfg.output_mode |-> m_tdata[23:0] == 24'd0 && m_tdata[55:32] == 24'd0)
    else $error("color field set in gray mode");
`endif

endmodule

@@ verif/yuyv_color_keyed_converter_tb.sv @@
// self-checking testbench for the yuyv color keyed converter
module yuyv_color_keyed_converter_tb;
  import yck_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    pix_t first;
    pix_t second;
    logic frame_end;
  } pixel_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  cfg_t key_cfg;
  pixel_pair_t expected_pairs[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  bit hold_request = 1'b0;
  int cycle_count = 0;
  int error_count = 0;
  int pairs_sent = 0;
  int pairs_checked = 0;
  int pixels_dropped = 0;

  yuyv_color_keyed_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("yuyv_color_keyed_converter verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] clamp_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic pix_t shade_pixel(logic [7:0] y, logic keep, int cb, int cg, int cr);
    pix_t p;
    p = '0;
    p.write = keep;
    if (keep) begin
      if (key_cfg.output_mode) begin
        p.blue  = clamp_byte(int'(y) + cb);
        p.green = clamp_byte(int'(y) - cg);
        p.red   = clamp_byte(int'(y) + cr);
      end else begin
        p.gray = y;
      end
    end
    return p;
  endfunction

  function automatic pixel_pair_t predict_pair(logic [31:0] data, logic last);
    logic [7:0] y0, u, y1, v;
    int du, dv, cb, cr, cg;
    logic chroma_ok, keep0, keep1;
    pixel_pair_t r;
    y0 = data[7:0];
    u  = data[15:8];
    y1 = data[23:16];
    v  = data[31:24];
    du = int'(u) - 128;
    dv = int'(v) - 128;
    // arithmetic shift of a signed int floors toward minus infinity
    cb = (du * int'(CoefBlueU)) >>> 8;
    cr = (dv * int'(CoefRedV)) >>> 8;
    cg = (du * int'(CoefGreenU) + dv * int'(CoefGreenV)) >>> 8;
    keep0 = 1'b1;
    keep1 = 1'b1;
    if (key_cfg.filter_enable) begin
      chroma_ok = u >= key_cfg.blue_diff_min && u <= key_cfg.blue_diff_max &&
                  v >= key_cfg.red_diff_min && v <= key_cfg.red_diff_max;
      keep0 = chroma_ok && y0 >= key_cfg.luma_min && y0 <= key_cfg.luma_max;
      keep1 = chroma_ok && y1 >= key_cfg.luma_min && y1 <= key_cfg.luma_max;
    end
    r.first = shade_pixel(y0, keep0, cb, cg, cr);
    r.second = shade_pixel(y1, keep1, cb, cg, cr);
    r.frame_end = last;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_pixel(string tag, pix_t want, pix_t got);
    check_field({tag, "_write"}, 8'(want.write), 8'(got.write));
    check_field({tag, "_blue"}, want.blue, got.blue);
    check_field({tag, "_green"}, want.green, got.green);
    check_field({tag, "_red"}, want.red, got.red);
    check_field({tag, "_gray"}, want.gray, got.gray);
  endtask

  // input items are predicted before results are checked, in one process
  always @(posedge clk) begin
    pixel_pair_t want, got;
    if (!rst && s_tvalid && s_tready === 1'b1) begin
      expected_pairs.push_back(predict_pair(s_tdata, s_tlast));
      pairs_sent++;
    end
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got.first  = '{m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
      got.second = '{m_tuser[1], m_tdata[39:32], m_tdata[47:40], m_tdata[55:48],
                     m_tdata[63:56]};
      got.frame_end = m_tlast;
      if (expected_pairs.size() == 0) begin
        $error("result item with no pending macropixel");
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        check_pixel("first", want.first, got.first);
        check_pixel("second", want.second, got.second);
        check_field("frame_end_out", 8'(want.frame_end), 8'(got.frame_end));
        pixels_dropped += int'(!want.first.write) + int'(!want.second.write);
        pairs_checked++;
      end
    end
  end

  // output side ready, with a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_cycles = 60;
      hold_request = 1'b0;
    end
    if (hold_cycles > 0) begin
      m_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_macropixel(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                 logic [7:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {v, y1, u, y0};
    s_tlast = last;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [7:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_OUTPUT_MODE:   key_cfg.output_mode = val[0];
      REG_FILTER_ENABLE: key_cfg.filter_enable = val[0];
      REG_LUMA_MIN:      key_cfg.luma_min = val;
      REG_LUMA_MAX:      key_cfg.luma_max = val;
      REG_BLUE_DIFF_MIN: key_cfg.blue_diff_min = val;
      REG_BLUE_DIFF_MAX: key_cfg.blue_diff_max = val;
      REG_RED_DIFF_MIN:  key_cfg.red_diff_min = val;
      default:           key_cfg.red_diff_max = val;
    endcase
  endtask

  task automatic set_window(cfg_reg_t lo_reg, cfg_reg_t hi_reg);
    logic [7:0] lo, hi;
    lo = 8'($urandom_range(255));
    case ($urandom_range(7))
      0: begin
        // inverted window rejects everything
        if (lo == 8'd0) lo = 8'd1;
        hi = 8'($urandom_range(lo - 1, 0));
      end
      1: begin
        lo = 8'd0;
        hi = 8'd255;
      end
      2: begin
        lo = $urandom_range(1) ? 8'd255 : 8'd0;
        hi = lo;
      end
      default: hi = 8'($urandom_range(255, lo));
    endcase
    set_reg(lo_reg, lo);
    set_reg(hi_reg, hi);
  endtask

  task automatic randomize_key();
    set_reg(REG_OUTPUT_MODE, 8'($urandom_range(1)));
    set_reg(REG_FILTER_ENABLE, 8'($urandom_range(2) != 0));
    set_window(REG_LUMA_MIN, REG_LUMA_MAX);
    set_window(REG_BLUE_DIFF_MIN, REG_BLUE_DIFF_MAX);
    set_window(REG_RED_DIFF_MIN, REG_RED_DIFF_MAX);
  endtask

  // mostly inside the window, often on its edges, sometimes anywhere
  function automatic logic [7:0] pick_byte(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: begin
        case ($urandom_range(3))
          0: return lo - 8'd1;
          1: return lo;
          2: return hi;
          default: return hi + 8'd1;
        endcase
      end
      default: return (lo <= hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_item();
    logic [7:0] y0, u, y1, v;
    if (key_cfg.filter_enable) begin
      y0 = pick_byte(key_cfg.luma_min, key_cfg.luma_max);
      u  = pick_byte(key_cfg.blue_diff_min, key_cfg.blue_diff_max);
      y1 = pick_byte(key_cfg.luma_min, key_cfg.luma_max);
      v  = pick_byte(key_cfg.red_diff_min, key_cfg.red_diff_max);
    end else begin
      {y0, u, y1, v} = $urandom;
    end
    send_macropixel(y0, u, y1, v, $urandom_range(7) == 0);
  endtask

  task automatic test_color_extremes();
    send_macropixel(8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    // chroma one step either side of zero exercises the floor
    send_macropixel(8'd16, 8'd127, 8'd235, 8'd129, 1'b1);
    wait_idle();
  endtask

  task automatic test_gray_mode();
    set_reg(REG_OUTPUT_MODE, 8'd0);
    send_macropixel(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
    send_macropixel(8'd77, 8'd128, 8'd200, 8'd3, 1'b0);
    wait_idle();
  endtask

  task automatic test_filter_windows();
    set_reg(REG_OUTPUT_MODE, 8'd1);
    set_reg(REG_FILTER_ENABLE, 8'd1);
    set_reg(REG_LUMA_MIN, 8'd16);
    set_reg(REG_LUMA_MAX, 8'd235);
    set_reg(REG_BLUE_DIFF_MIN, 8'd100);
    set_reg(REG_BLUE_DIFF_MAX, 8'd150);
    set_reg(REG_RED_DIFF_MIN, 8'd90);
    set_reg(REG_RED_DIFF_MAX, 8'd160);
    send_macropixel(8'd16, 8'd100, 8'd235, 8'd160, 1'b0);
    send_macropixel(8'd15, 8'd150, 8'd236, 8'd90, 1'b0);
    send_macropixel(8'd20, 8'd120, 8'd240, 8'd120, 1'b1);
    send_macropixel(8'd100, 8'd99, 8'd100, 8'd120, 1'b0);
    send_macropixel(8'd100, 8'd151, 8'd100, 8'd120, 1'b0);
    send_macropixel(8'd100, 8'd120, 8'd100, 8'd89, 1'b0);
    send_macropixel(8'd100, 8'd120, 8'd100, 8'd161, 1'b1);
    wait_idle();
    set_reg(REG_OUTPUT_MODE, 8'd0);
    send_macropixel(8'd10, 8'd120, 8'd50, 8'd120, 1'b0);
    wait_idle();
    // inverted luma window drops every pixel
    set_reg(REG_LUMA_MIN, 8'd200);
    set_reg(REG_LUMA_MAX, 8'd100);
    send_macropixel(8'd150, 8'd120, 8'd150, 8'd120, 1'b0);
    wait_idle();
    set_reg(REG_LUMA_MIN, 8'd0);
    set_reg(REG_LUMA_MAX, 8'd255);
    set_reg(REG_BLUE_DIFF_MIN, 8'd255);
    set_reg(REG_BLUE_DIFF_MAX, 8'd0);
    send_macropixel(8'd150, 8'd128, 8'd0, 8'd128, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_reg(REG_OUTPUT_MODE, 8'd1);
    set_reg(REG_FILTER_ENABLE, 8'd0);
    hold_request = 1'b1;
    repeat (30) send_random_item();
    wait_idle();
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (5) begin
      wait_idle();
      randomize_key();
      repeat (36) send_random_item();
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0);
    run_random_phase(61, 0);
    run_random_phase(0, 61);
    run_random_phase(37, 37);
  endtask

  initial begin
    key_cfg = '{output_mode: 1'b1, filter_enable: 1'b0, luma_min: 8'd0, luma_max: 8'd255,
                blue_diff_min: 8'd0, blue_diff_max: 8'd255,
                red_diff_min: 8'd0, red_diff_max: 8'd255};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_color_extremes();
    test_gray_mode();
    test_filter_windows();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (10) @(negedge clk);
    if (expected_pairs.size() != 0) begin
      $error("%0d macropixels never produced a result", expected_pairs.size());
      error_count++;
    end
    $display("%0d macropixels sent, %0d pixel pairs checked, %0d pixels keyed out",
             pairs_sent, pairs_checked, pixels_dropped);
    $display("color and gray modes, key windows incl. inverted, idle and stall mixes, long hold");
    if (error_count == 0) begin
      $display("yuyv_color_keyed_converter verification clean");
    end else begin
      $display("yuyv_color_keyed_converter verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/yck_pkg.sv
sv/yck_chroma.sv
sv/yck_pixel.sv
sv/yuyv_color_keyed_converter.sv
verif/yuyv_color_keyed_converter_tb.sv
